/* rtl/q8bqd_pkg.sv */
// Shared types, constants and helpers for the quantized block dot product.
// Used by q8bqd_norm_round and q8_block_quant_dot; depends on nothing.
package q8bqd_pkg;

    localparam int LANES_DEF = 4;
    localparam int SUM_W     = 21;
    localparam int NR_MANT_W = 48;
    localparam int NR_EXP_W  = 11;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_TERM_GO,
        ST_TERM_WAIT,
        ST_ADD_GO,
        ST_ADD_WAIT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        NR_IDLE,
        NR_LEFT,
        NR_RIGHT,
        NR_ROUND
    } t_nr_state;

    // value = mant * 2^exp, sign apart
    typedef struct packed {
        logic                       start;
        logic                       sign;
        logic [NR_MANT_W-1:0]       mant;
        logic signed [NR_EXP_W-1:0] exp;
    } t_nr_req;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } t_nr_rsp;

    // Integer significand of a half: implicit bit plus fraction
    function automatic logic [10:0] half_mant(input logic [15:0] h);
        return {h[14:10] != 5'd0, h[9:0]};
    endfunction

    // Exponent that goes with half_mant: value = mant * 2^exp
    function automatic logic signed [NR_EXP_W-1:0] half_exp(input logic [15:0] h);
        logic [4:0] e;
        e = h[14:10];
        if (e == 5'd0) begin
            return -11'sd24;
        end
        return $signed({6'b0, e}) - 11'sd25;
    endfunction

endpackage

/* rtl/q8bqd_norm_round.sv */
// Normalize and round to single precision, nearest even, one shift a cycle.
// Depends on q8bqd_pkg for the request and response structs.
module q8bqd_norm_round (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  q8bqd_pkg::t_nr_req i_req,
    output q8bqd_pkg::t_nr_rsp o_rsp
);

    q8bqd_pkg::t_nr_state r_state, n_state;
    logic [q8bqd_pkg::NR_MANT_W-1:0]       r_m;
    logic signed [q8bqd_pkg::NR_EXP_W-1:0] r_be;
    logic        r_sign;
    logic        r_done;
    logic [31:0] r_res;

    logic        w_inc;
    logic [24:0] w_rnd;
    logic [23:0] w_mant;
    logic signed [q8bqd_pkg::NR_EXP_W-1:0] w_expf;
    logic [31:0] w_res;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            q8bqd_pkg::NR_IDLE: begin
                if (i_req.start && (i_req.mant != '0)) begin
                    n_state = q8bqd_pkg::NR_LEFT;
                end
            end
            q8bqd_pkg::NR_LEFT: begin
                if (r_m[q8bqd_pkg::NR_MANT_W-1]) begin
                    n_state = (r_be < 11'sd1) ? q8bqd_pkg::NR_RIGHT : q8bqd_pkg::NR_ROUND;
                end
            end
            q8bqd_pkg::NR_RIGHT: begin
                if (r_be >= 11'sd1) begin
                    n_state = q8bqd_pkg::NR_ROUND;
                end
            end
            q8bqd_pkg::NR_ROUND: n_state = q8bqd_pkg::NR_IDLE;
            default: n_state = q8bqd_pkg::NR_IDLE;
        endcase
    end

    // round on the top 24 bits, guard below, rest sticky
    always_comb begin
        w_inc = r_m[23] & ((|r_m[22:0]) | r_m[24]);
        w_rnd = {1'b0, r_m[47:24]} + {24'b0, w_inc};
        if (w_rnd[24]) begin
            w_mant = w_rnd[24:1];
            w_expf = r_be + 11'sd1;
        end else begin
            w_mant = w_rnd[23:0];
            w_expf = w_rnd[23] ? r_be : 11'sd0;
        end
        if (w_expf >= 11'sd255) begin
            w_res = {r_sign, 8'hFF, 23'b0};
        end else begin
            w_res = {r_sign, w_expf[7:0], w_mant[22:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= q8bqd_pkg::NR_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            unique case (r_state)
                q8bqd_pkg::NR_IDLE: begin
                    if (i_req.start) begin
                        r_m    <= i_req.mant;
                        r_be   <= i_req.exp + 11'sd174;
                        r_sign <= i_req.sign;
                        if (i_req.mant == '0) begin
                            r_res  <= {i_req.sign, 31'b0};
                            r_done <= 1'b1;
                        end
                    end
                end
                q8bqd_pkg::NR_LEFT: begin
                    if (!r_m[q8bqd_pkg::NR_MANT_W-1]) begin
                        r_m  <= {r_m[q8bqd_pkg::NR_MANT_W-2:0], 1'b0};
                        r_be <= r_be - 11'sd1;
                    end
                end
                q8bqd_pkg::NR_RIGHT: begin
                    if (r_be < 11'sd1) begin
                        // keep lost bits sticky in the lsb
                        r_m  <= {1'b0, r_m[q8bqd_pkg::NR_MANT_W-1:2], r_m[1] | r_m[0]};
                        r_be <= r_be + 11'sd1;
                    end
                end
                q8bqd_pkg::NR_ROUND: begin
                    r_res  <= w_res;
                    r_done <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

/* rtl/q8_block_quant_dot.sv */
// Quantized block dot product: int8 lane products, half scales, float running sum.
// Depends on q8bqd_pkg and q8bqd_norm_round.
//
//  channel  dir  tdata fields (low bit up)                      side bits
//  s        in   x_elem0..LANES-1, y_elem0..LANES-1, x_scale,   tuser=block_end
//                y_scale                                        tlast=vector_end
//  m        out  dot_result                                     -
//
// An item ending neither a block nor a vector only adds to the block sum. A block
// or vector end item holds tready low for the float work: two multiplies, then the
// shared normalize/round unit on the term and on a finite add, one shift a cycle.
// Reset is synchronous, active low, and clears the sums and the sequencer.
// A vector result waits in the output register; a later vector end stalls
// until it is taken.
module q8_block_quant_dot #(
    parameter int LANES = q8bqd_pkg::LANES_DEF,
    localparam int DATA_W = 16 * LANES + 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // x_elem0..x_elem[LANES-1], y_elem0..y_elem[LANES-1], x_scale, y_scale
    input  logic [DATA_W-1:0] i_s_tdata,
    // block_end
    input  logic              i_s_tuser,
    input  logic              i_s_tlast,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // dot_result
    output logic [31:0]       o_m_tdata
);

    localparam int SW = q8bqd_pkg::SUM_W;

    q8bqd_pkg::t_state r_state, n_state;

    logic [SW-1:0] r_acc, r_blk, r_mag;
    logic [15:0]   r_xs, r_ys;
    logic          r_vend;
    logic [31:0]   r_sum, r_term;
    logic [21:0]   r_pm;
    logic [42:0]   r_prod;
    logic signed [q8bqd_pkg::NR_EXP_W-1:0] r_texp;
    logic          r_tsign, r_tnan, r_tinf;
    logic          r_out_valid;
    logic [31:0]   r_out_data;

    logic          w_acc;
    logic [SW-1:0] w_item_sum;
    q8bqd_pkg::t_nr_req w_req;
    q8bqd_pkg::t_nr_rsp w_rsp;
    logic          w_out_load;

    assign w_acc = i_s_tvalid && o_s_tready;

    always_comb begin
        w_item_sum = '0;
        for (int k = 0; k < LANES; k++) begin
            w_item_sum = w_item_sum + SW'($signed(i_s_tdata[8*k +: 8])
                                        * $signed(i_s_tdata[8*(LANES+k) +: 8]));
        end
    end

    // scale classes
    logic w_xzero, w_xinf, w_xnan, w_yzero, w_yinf, w_ynan, w_tnan;
    always_comb begin
        w_xzero = (r_xs[14:0] == 15'd0);
        w_yzero = (r_ys[14:0] == 15'd0);
        w_xinf  = (r_xs[14:10] == 5'h1F) && (r_xs[9:0] == 10'd0);
        w_yinf  = (r_ys[14:10] == 5'h1F) && (r_ys[9:0] == 10'd0);
        w_xnan  = (r_xs[14:10] == 5'h1F) && (r_xs[9:0] != 10'd0);
        w_ynan  = (r_ys[14:10] == 5'h1F) && (r_ys[9:0] != 10'd0);
        w_tnan  = w_xnan || w_ynan || (w_xinf && w_yzero) || (w_yinf && w_xzero)
                  || ((w_xinf || w_yinf) && (r_blk == '0));
    end

    // float add of running sum and term: unpack, align, add
    logic [7:0]  w_ea, w_eb, w_ebig, w_esml, w_d;
    logic [23:0] w_ma, w_mb, w_mbig, w_msml;
    logic        w_swap, w_sub, w_anan, w_bnan, w_ainf, w_binf;
    logic        w_add_spec, w_add_sign;
    logic [31:0] w_add_spec_val;
    logic [26:0] w_ext, w_al, w_lost;
    logic [27:0] w_r;
    logic signed [q8bqd_pkg::NR_EXP_W-1:0] w_add_exp;

    always_comb begin
        w_ea   = (r_sum[30:23] == 8'd0) ? 8'd1 : r_sum[30:23];
        w_eb   = (r_term[30:23] == 8'd0) ? 8'd1 : r_term[30:23];
        w_ma   = {r_sum[30:23] != 8'd0, r_sum[22:0]};
        w_mb   = {r_term[30:23] != 8'd0, r_term[22:0]};
        w_swap = {w_eb, w_mb} > {w_ea, w_ma};
        w_ebig = w_swap ? w_eb : w_ea;
        w_esml = w_swap ? w_ea : w_eb;
        w_mbig = w_swap ? w_mb : w_ma;
        w_msml = w_swap ? w_ma : w_mb;
        w_sub  = r_sum[31] ^ r_term[31];
        w_d    = w_ebig - w_esml;
        w_ext  = {w_msml, 3'b0};
        if (w_d >= 8'd27) begin
            w_lost = '1;
            w_al   = {26'b0, |w_msml};
        end else begin
            w_lost = ~(27'h7FF_FFFF << w_d[4:0]);
            w_al   = (w_ext >> w_d[4:0]) | {26'b0, |(w_ext & w_lost)};
        end
        if (w_sub) begin
            w_r = {1'b0, w_mbig, 3'b0} - {1'b0, w_al};
        end else begin
            w_r = {1'b0, w_mbig, 3'b0} + {1'b0, w_al};
        end
        if (w_r == '0) begin
            w_add_sign = r_sum[31] & r_term[31];
        end else begin
            w_add_sign = w_swap ? r_term[31] : r_sum[31];
        end
        w_add_exp = $signed({3'b0, w_ebig}) - 11'sd153;

        w_anan = (r_sum[30:23] == 8'hFF) && (r_sum[22:0] != 23'd0);
        w_bnan = (r_term[30:23] == 8'hFF) && (r_term[22:0] != 23'd0);
        w_ainf = (r_sum[30:23] == 8'hFF) && (r_sum[22:0] == 23'd0);
        w_binf = (r_term[30:23] == 8'hFF) && (r_term[22:0] == 23'd0);
        w_add_spec = w_anan || w_bnan || w_ainf || w_binf;
        if (w_anan || w_bnan || (w_ainf && w_binf && w_sub)) begin
            w_add_spec_val = q8bqd_pkg::CANON_NAN;
        end else if (w_ainf) begin
            w_add_spec_val = r_sum;
        end else begin
            w_add_spec_val = r_term;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            q8bqd_pkg::ST_IDLE: begin
                if (w_acc && (i_s_tuser || i_s_tlast)) begin
                    n_state = q8bqd_pkg::ST_MUL1;
                end
            end
            q8bqd_pkg::ST_MUL1:      n_state = q8bqd_pkg::ST_MUL2;
            q8bqd_pkg::ST_MUL2:      n_state = q8bqd_pkg::ST_TERM_GO;
            q8bqd_pkg::ST_TERM_GO:   n_state = q8bqd_pkg::ST_TERM_WAIT;
            q8bqd_pkg::ST_TERM_WAIT: begin
                if (w_rsp.done) begin
                    n_state = q8bqd_pkg::ST_ADD_GO;
                end
            end
            q8bqd_pkg::ST_ADD_GO: begin
                n_state = w_add_spec ? q8bqd_pkg::ST_DONE : q8bqd_pkg::ST_ADD_WAIT;
            end
            q8bqd_pkg::ST_ADD_WAIT: begin
                if (w_rsp.done) begin
                    n_state = q8bqd_pkg::ST_DONE;
                end
            end
            q8bqd_pkg::ST_DONE: begin
                if (!r_vend || !r_out_valid || i_m_tready) begin
                    n_state = q8bqd_pkg::ST_IDLE;
                end
            end
            default: n_state = q8bqd_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_tready = 1'b0;
        w_out_load = 1'b0;
        w_req      = '0;
        unique case (r_state)
            q8bqd_pkg::ST_IDLE: o_s_tready = 1'b1;
            q8bqd_pkg::ST_TERM_GO: begin
                w_req.start = 1'b1;
                w_req.sign  = r_tsign;
                w_req.mant  = {5'b0, r_prod};
                w_req.exp   = r_texp;
            end
            q8bqd_pkg::ST_ADD_GO: begin
                w_req.start = !w_add_spec;
                w_req.sign  = w_add_sign;
                w_req.mant  = {20'b0, w_r};
                w_req.exp   = w_add_exp;
            end
            q8bqd_pkg::ST_DONE: begin
                w_out_load = r_vend && (!r_out_valid || i_m_tready);
            end
            default: ;
        endcase
    end

    q8bqd_norm_round u_norm_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= q8bqd_pkg::ST_IDLE;
            r_acc       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_acc) begin
                if (i_s_tuser || i_s_tlast) begin
                    r_blk  <= r_acc + w_item_sum;
                    r_acc  <= '0;
                    r_xs   <= i_s_tdata[16*LANES +: 16];
                    r_ys   <= i_s_tdata[16*LANES+16 +: 16];
                    r_vend <= i_s_tlast;
                end else begin
                    r_acc <= r_acc + w_item_sum;
                end
            end
            unique case (r_state)
                q8bqd_pkg::ST_MUL1: begin
                    r_pm    <= q8bqd_pkg::half_mant(r_xs) * q8bqd_pkg::half_mant(r_ys);
                    r_texp  <= q8bqd_pkg::half_exp(r_xs) + q8bqd_pkg::half_exp(r_ys);
                    r_mag   <= r_blk[SW-1] ? (~r_blk + 1'b1) : r_blk;
                    r_tsign <= r_xs[15] ^ r_ys[15] ^ r_blk[SW-1];
                    r_tnan  <= w_tnan;
                    r_tinf  <= (w_xinf || w_yinf) && !w_tnan;
                end
                q8bqd_pkg::ST_MUL2: begin
                    r_prod <= r_pm * r_mag;
                end
                q8bqd_pkg::ST_TERM_WAIT: begin
                    if (w_rsp.done) begin
                        if (r_tnan) begin
                            r_term <= q8bqd_pkg::CANON_NAN;
                        end else if (r_tinf) begin
                            r_term <= {r_tsign, 8'hFF, 23'b0};
                        end else begin
                            r_term <= w_rsp.result;
                        end
                    end
                end
                q8bqd_pkg::ST_ADD_GO: begin
                    if (w_add_spec) begin
                        r_sum <= w_add_spec_val;
                    end
                end
                q8bqd_pkg::ST_ADD_WAIT: begin
                    if (w_rsp.done) begin
                        r_sum <= w_rsp.result;
                    end
                end
                default: ;
            endcase
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= r_sum;
                r_sum       <= '0;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_block_end_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_s_tuser || i_s_tlast)) |=> !o_s_tready)
        else $error("input not held off after a block end beat");

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_s_tuser || i_s_tlast)) |=> (r_acc == '0))
        else $error("block accumulator not cleared on block end");

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == q8bqd_pkg::ST_TERM_WAIT
                        || r_state == q8bqd_pkg::ST_ADD_WAIT))
        else $error("rounding unit finished outside a wait state");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == q8bqd_pkg::ST_DONE && $past(r_vend)))
        else $error("result raised without a finished vector");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_sum == '0))
        else $error("running sum not cleared after vector end");

endmodule

/* dv/q8_block_quant_dot_checker.sv */
// Checker for q8_block_quant_dot: watches both stream channels, predicts each dot result
// with an integer-only single-precision model, and compares. Depends on nothing but the ports.
module q8_block_quant_dot_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // x_elem0..3, y_elem0..3, x_scale, y_scale
    input  logic [95:0] i_s_tdata,
    // block_end
    input  logic        i_s_tuser,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // dot_result
    input  logic [31:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    logic [20:0] blk_sum;
    logic [31:0] run_sum;
    logic [31:0] dot_q[$];

    function automatic logic [31:0] half_widen(input logic [15:0] h);
        logic [31:0] sgn;
        logic [4:0]  ex;
        logic [9:0]  mt;
        int          se;
        sgn = {h[15], 31'b0};
        ex  = h[14:10];
        mt  = h[9:0];
        if (ex == 5'd0) begin
            if (mt == 10'd0) return sgn;
            se = 113;
            while (mt[9] == 1'b0) begin
                mt = mt << 1;
                se--;
            end
            mt = mt << 1;
            se--;
            // leading one is now shifted out; remaining fraction in mt
            return sgn | (32'(se) << 23) | (32'(mt) << 13);
        end
        if (ex == 5'd31) return sgn | 32'h7F80_0000 | (32'(mt) << 13);
        return sgn | (32'(ex + 112) << 23) | (32'(mt) << 13);
    endfunction

    function automatic logic is_nan(input logic [31:0] f);
        return f[30:23] == 8'hFF && f[22:0] != 23'd0;
    endfunction

    function automatic logic is_inf(input logic [31:0] f);
        return f[30:23] == 8'hFF && f[22:0] == 23'd0;
    endfunction

    function automatic void f32_unpack(input logic [31:0] f, output logic [63:0] m,
                                       output int e);
        if (f[30:23] == 8'd0) begin
            m = 64'(f[22:0]);
            e = -149;
        end else begin
            m = 64'({1'b1, f[22:0]});
            e = int'(f[30:23]) - 150;
        end
    endfunction

    // Round sign * m * 2^e to single, nearest even, with subnormals and overflow.
    function automatic logic [31:0] f32_round(input logic sgn, input logic [63:0] m,
                                              input int e);
        int           p;
        int           ex;
        int           lsb;
        int           sh;
        int           be;
        logic [63:0]  q;
        logic [127:0] w;
        if (m == 64'd0) return {sgn, 31'b0};
        p = 0;
        for (int i = 0; i < 64; i++) if (m[i]) p = i;
        ex  = p + e;
        lsb = (ex - 23 > -149) ? ex - 23 : -149;
        sh  = lsb - e;
        if (sh <= 0) begin
            q = m << (-sh);
        end else if (sh > 64) begin
            q = 64'd0;
        end else begin
            w = {m, 64'b0} >> sh;
            q = w[127:64];
            if (w[63:0] > 64'h8000_0000_0000_0000 ||
                (w[63:0] == 64'h8000_0000_0000_0000 && q[0])) q = q + 1;
        end
        if (q[24]) begin
            q = q >> 1;
            lsb++;
        end
        if (q[23]) begin
            be = lsb + 150;
            if (be >= 255) return {sgn, 8'hFF, 23'd0};
            return {sgn, 8'(be), q[22:0]};
        end
        return {sgn, 8'd0, q[22:0]};
    endfunction

    function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        int          ea;
        int          eb;
        logic        sgn;
        sgn = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return QNAN;
        if (is_inf(a) || is_inf(b)) begin
            if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return QNAN;
            return {sgn, 8'hFF, 23'd0};
        end
        f32_unpack(a, ma, ea);
        f32_unpack(b, mb, eb);
        return f32_round(sgn, ma * mb, ea + eb);
    endfunction

    function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] big;
        logic [63:0] sml;
        logic [63:0] tmp;
        int          ea;
        int          eb;
        int          d;
        logic        sa;
        logic        sb;
        logic        st;
        if (is_nan(a) || is_nan(b)) return QNAN;
        if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : QNAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        f32_unpack(a, ma, ea);
        f32_unpack(b, mb, eb);
        sa = a[31];
        sb = b[31];
        if (ma == 64'd0 && mb == 64'd0) return {sa & sb, 31'b0};
        if (ma == 64'd0) return b;
        if (mb == 64'd0) return a;
        if (eb > ea) begin
            tmp = ma; ma = mb; mb = tmp;
            d = ea; ea = eb; eb = d;
            st = sa; sa = sb; sb = st;
        end
        d   = ea - eb;
        big = ma << 30;
        if (d > 60) begin
            sml = 64'd1;
        end else begin
            tmp = mb << 30;
            sml = tmp >> d;
            // fold shifted-out bits into a sticky lsb
            if ((tmp & ((64'd1 << d) - 64'd1)) != 64'd0) sml = sml | 64'd1;
        end
        if (sa == sb) return f32_round(sa, big + sml, ea - 30);
        if (big == sml) return 32'd0;
        if (big > sml) return f32_round(sa, big - sml, ea - 30);
        return f32_round(sb, sml - big, ea - 30);
    endfunction

    function automatic logic [31:0] int21_to_f32(input logic [20:0] v);
        logic [20:0] mag;
        mag = ~v + 21'd1;
        if (v[20]) return f32_round(1'b1, 64'(mag), 0);
        return f32_round(1'b0, 64'(v), 0);
    endfunction

    always_ff @(posedge i_clk) begin
        logic [20:0] acc;
        logic [31:0] scl;
        logic [31:0] tot;
        logic [31:0] exp_dot;
        if (!i_rst_n) begin
            blk_sum      <= '0;
            run_sum      <= '0;
            o_fail_count <= 0;
            dot_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                acc = blk_sum;
                for (int i = 0; i < 4; i++) begin
                    acc = acc + 21'($signed(i_s_tdata[8*i +: 8]) *
                                    $signed(i_s_tdata[32 + 8*i +: 8]));
                end
                tot = run_sum;
                if (i_s_tuser || i_s_tlast) begin
                    scl = f32_mul(half_widen(i_s_tdata[79:64]),
                                  half_widen(i_s_tdata[95:80]));
                    tot = f32_add(run_sum, f32_mul(int21_to_f32(acc), scl));
                    if (is_nan(tot)) tot = QNAN;
                    acc = '0;
                end
                blk_sum <= acc;
                run_sum <= i_s_tlast ? 32'd0 : tot;
                if (i_s_tlast) dot_q.push_back(tot);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (dot_q.size() == 0) begin
                    $error("unexpected beat: dot_result actual %h", i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_dot = dot_q.pop_front();
                    if (exp_dot !== i_m_tdata) begin
                        $error("dot_result mismatch: expected %h actual %h",
                               exp_dot, i_m_tdata);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

    assign o_pending = dot_q.size();

endmodule

/* dv/tb_q8_block_quant_dot.sv */
// Top of the q8_block_quant_dot testbench: clock, reset, stream stimulus and verdict.
// Depends on q8_block_quant_dot and q8_block_quant_dot_checker.
module tb_q8_block_quant_dot;

    localparam int WDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES = 500;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    int          fail_count;
    int          pending;
    int          item_cnt = 0;
    int          idle_cycles = 0;
    bit          busy_sender = 0;

    always #2 i_clk = ~i_clk;

    q8_block_quant_dot u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    q8_block_quant_dot_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (busy_sender || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Offer one beat; valid stays high into the next beat when there is no gap.
    task automatic send_beat(input logic [31:0] xv, input logic [31:0] yv,
                             input logic [15:0] xs, input logic [15:0] ys,
                             input logic bend, input logic vend);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tdata  = {ys, xs, yv, xv};
        s_tuser  = bend;
        s_tlast  = vend;
        s_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_tready);
        item_cnt++;
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_scale();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return {1'($urandom), 5'($urandom_range(8, 20)), 10'($urandom)};
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] rand_elems();
        if ($urandom_range(0, 9) == 0) return {4{($urandom_range(0, 1) != 0) ? 8'h80 : 8'h7F}};
        return $urandom;
    endfunction

    // One block of n beats; the last carries the scales and the end marks.
    task automatic send_block(input int n, input logic vend, input logic bend_on_last);
        logic [15:0] xs;
        logic [15:0] ys;
        xs = rand_scale();
        ys = rand_scale();
        for (int i = 0; i < n; i++) begin
            if (i == n - 1)
                send_beat(rand_elems(), rand_elems(), xs, ys, bend_on_last, vend);
            else
                send_beat(rand_elems(), rand_elems(), 16'($urandom), 16'($urandom),
                          1'b0, 1'b0);
        end
    endtask

    task automatic send_const_block(input logic [7:0] xe, input logic [7:0] ye, input int n,
                                    input logic [15:0] xs, input logic [15:0] ys,
                                    input logic vend);
        for (int i = 0; i < n; i++)
            send_beat({4{xe}}, {4{ye}}, xs, ys, i == n - 1, vend && (i == n - 1));
    endtask

    // Receiver: random stalls, plus one long hold-off so the block backs up.
    initial begin
        int cyc;
        int hold;
        cyc  = 0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc == 1500) hold = HOLD_CYCLES;
            if (hold > 0) begin
                hold--;
                m_tready = 1'b0;
            end else if ($urandom_range(0, 99) < 5) begin
                hold = $urandom_range(10, 60);
                m_tready = 1'b0;
            end else begin
                m_tready = ($urandom_range(0, 99) < 70);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Extremes of the lanes, special half scales, wrap and odd block shapes.
        send_const_block(8'h80, 8'h80, 8, 16'h3C00, 16'h3C00, 1'b0);
        send_const_block(8'h80, 8'h7F, 8, 16'h7BFF, 16'hFBFF, 1'b1);
        send_const_block(8'h7F, 8'h7F, 2, 16'h0001, 16'h03FF, 1'b1);
        send_const_block(8'h01, 8'h01, 1, 16'h7C00, 16'h3C00, 1'b0);
        send_const_block(8'h01, 8'hFF, 1, 16'h7C00, 16'h3C00, 1'b1);
        send_const_block(8'h05, 8'h03, 1, 16'h7E00, 16'h3C00, 1'b1);
        send_const_block(8'h00, 8'h00, 1, 16'h7C00, 16'h3C00, 1'b1);
        send_const_block(8'h02, 8'h02, 1, 16'h8000, 16'h3C00, 1'b1);
        // run a block past its size so the integer sum wraps
        send_const_block(8'h80, 8'h80, 17, 16'h3C00, 16'h3C00, 1'b1);
        // vector end without a block end
        send_beat({4{8'h7F}}, {4{8'h80}}, 16'h3800, 16'h4000, 1'b0, 1'b1);

        while (item_cnt < 850) begin
            int nblk;
            int r;
            busy_sender = ($urandom_range(0, 3) == 0);
            nblk = $urandom_range(1, 4);
            for (int b = 0; b < nblk; b++) begin
                r = $urandom_range(0, 99);
                if (r < 85)
                    send_block(8, b == nblk - 1, 1'b1);
                else if (r < 92)
                    send_block($urandom_range(1, 7), b == nblk - 1, 1'b1);
                else if (r < 96)
                    send_block($urandom_range(9, 20), b == nblk - 1, 1'b1);
                else
                    send_block(8, b == nblk - 1, b != nblk - 1 || $urandom_range(0, 1));
            end
        end
        s_tvalid = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
